FILE: hw/rtl/cdc_pkg.sv
package cdc_pkg;

  localparam int unsigned ADD_WIDTH  = 16;
  localparam int unsigned YEAR_WIDTH = 12;
  localparam int unsigned CMP_WIDTH  = (ADD_WIDTH > 9) ? ADD_WIDTH : 9;

  localparam logic [YEAR_WIDTH-1:0] YEAR_MAX = {YEAR_WIDTH{1'b1}};
  localparam logic [YEAR_WIDTH-1:0] YEAR_LO  = YEAR_WIDTH'(1900);
  localparam logic [YEAR_WIDTH-1:0] YEAR_HI  = YEAR_WIDTH'(2100);

  localparam logic [3:0] MONTH_JAN = 4'd1;
  localparam logic [3:0] MONTH_FEB = 4'd2;
  localparam logic [3:0] MONTH_DEC = 4'd12;
  localparam logic [4:0] DAY_FIRST = 5'd1;
  localparam logic [4:0] DAY_LAST  = 5'd31;

  localparam logic REQ_SET = 1'b0;
  localparam logic REQ_ADD = 1'b1;

  typedef struct packed {
    logic                  req_type;
    logic [3:0]            set_month;
    logic [4:0]            set_day;
    logic [YEAR_WIDTH-1:0] set_year;
    logic [ADD_WIDTH-1:0]  add_days;
  } req_t;

  typedef struct packed {
    logic [3:0]            prev_month;
    logic [4:0]            prev_day;
    logic [YEAR_WIDTH-1:0] prev_year;
    logic [3:0]            cur_month;
    logic [4:0]            cur_day;
    logic [YEAR_WIDTH-1:0] cur_year;
    logic                  year_overflow;
  } res_t;

  typedef struct packed {
    logic load;
    logic fix_day;
    logic step;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic is_add;
    logic rem_zero;
    logic year_inc;
  } stat_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LEAP,
    ST_FIX,
    ST_STEP,
    ST_DONE
  } state_e;

  // Inverse of an odd number modulo 2^YEAR_WIDTH, by Newton iteration.
  function automatic logic [YEAR_WIDTH-1:0] odd_inverse(input longint unsigned a);
    longint unsigned x;
    x = a;
    for (int i = 0; i < 6; i++) begin
      x = (x * (64'd2 - a * x)) & 64'h0000_0000_FFFF_FFFF;
    end
    return x[YEAR_WIDTH-1:0];
  endfunction

  localparam logic [YEAR_WIDTH-1:0] INV25     = odd_inverse(64'd25);
  localparam logic [YEAR_WIDTH-1:0] DIV25_LIM = YEAR_WIDTH'(((1 << YEAR_WIDTH) - 1) / 25);

  function automatic logic [4:0] month_length(input logic [3:0] month, input logic leap);
    logic [4:0] len;
    unique case (month)
      4'd2:                     len = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:  len = 5'd30;
      default:                  len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

FILE: hw/rtl/cdc_ctrl.sv
module cdc_ctrl
  import cdc_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_stall_o,
  output logic  out_valid_o,
  input  logic  out_stall_i,
  input  stat_t stat_i,
  output cmd_t  cmd_o
);

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_LEAP;
        end
      end
      ST_LEAP: begin
        state_d = stat_i.is_add ? ST_STEP : ST_FIX;
      end
      ST_FIX: begin
        cmd_o.fix_day = 1'b1;
        state_d       = ST_DONE;
      end
      ST_STEP: begin
        if (stat_i.rem_zero) begin
          state_d = ST_DONE;
        end else begin
          cmd_o.step = 1'b1;
          if (stat_i.year_inc) begin
            state_d = ST_LEAP;
          end
        end
      end
      ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign out_valid_d = cmd_o.out_load | (out_valid_q & out_stall_i);
  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

FILE: hw/rtl/cdc_dpath.sv
module cdc_dpath
  import cdc_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  req_t  req_i,
  input  cmd_t  cmd_i,
  output stat_t stat_o,
  output res_t  res_o
);

  logic [3:0]            month_q, month_d;
  logic [4:0]            day_q, day_d;
  logic [YEAR_WIDTH-1:0] year_q, year_d;
  logic                  leap_q, leap_d;
  logic [ADD_WIDTH-1:0]  rem_q, rem_d;
  logic                  is_add_q, is_add_d;
  logic                  ovf_q, ovf_d;
  logic [3:0]            prev_month_q;
  logic [4:0]            prev_day_q;
  logic [YEAR_WIDTH-1:0] prev_year_q;
  res_t                  res_q;

  logic [YEAR_WIDTH-1:0] prod;
  logic                  div25;
  logic [4:0]            len;
  logic [4:0]            left;
  logic [CMP_WIDTH-1:0]  rem_x, ylen_x, left_x, left1_x;
  logic                  year_jump;
  logic                  fits_month;
  logic [YEAR_WIDTH-1:0] year_inc;

  // A year is divisible by 25 exactly when its product with the modular inverse
  // of 25 stays at or below the largest multiple's quotient.
  assign prod   = year_q * INV25;
  assign div25  = (prod <= DIV25_LIM);
  assign leap_d = (year_q[1:0] == 2'b00) && (!div25 || (year_q[3:0] == 4'b0000));

  assign len      = month_length(month_q, leap_q);
  assign left     = len - day_q;
  assign rem_x    = CMP_WIDTH'(rem_q);
  assign ylen_x   = leap_q ? CMP_WIDTH'(366) : CMP_WIDTH'(365);
  assign left_x   = CMP_WIDTH'(left);
  assign left1_x  = left_x + CMP_WIDTH'(1);
  assign year_inc = year_q + YEAR_WIDTH'(1);

  assign year_jump  = (month_q == MONTH_JAN) && (day_q == DAY_FIRST) &&
                      (year_q != YEAR_MAX) && (rem_x >= ylen_x);
  assign fits_month = (rem_x <= left_x);

  assign stat_o.is_add   = is_add_q;
  assign stat_o.rem_zero = (rem_q == '0);
  assign stat_o.year_inc = year_jump ||
                           (!fits_month && (month_q >= MONTH_DEC) && (year_q != YEAR_MAX));

  always_comb begin
    month_d  = month_q;
    day_d    = day_q;
    year_d   = year_q;
    rem_d    = rem_q;
    is_add_d = is_add_q;
    ovf_d    = ovf_q;
    priority if (cmd_i.load) begin
      is_add_d = req_i.req_type;
      rem_d    = req_i.add_days;
      ovf_d    = 1'b0;
      if (req_i.req_type == REQ_SET) begin
        month_d = ((req_i.set_month >= MONTH_JAN) && (req_i.set_month <= MONTH_DEC)) ?
                  req_i.set_month : MONTH_JAN;
        year_d  = ((req_i.set_year >= YEAR_LO) && (req_i.set_year <= YEAR_HI)) ?
                  req_i.set_year : YEAR_LO;
        day_d   = req_i.set_day;
      end
    end else if (cmd_i.fix_day) begin
      day_d = ((day_q >= DAY_FIRST) && (day_q <= len)) ? day_q : DAY_FIRST;
    end else if (cmd_i.step) begin
      priority if (year_jump) begin
        rem_d  = ADD_WIDTH'(rem_x - ylen_x);
        year_d = year_inc;
      end else if (fits_month) begin
        day_d = day_q + rem_q[4:0];
        rem_d = '0;
      end else if (month_q >= MONTH_DEC) begin
        if (year_q == YEAR_MAX) begin
          day_d   = DAY_LAST;
          month_d = MONTH_DEC;
          ovf_d   = 1'b1;
          rem_d   = '0;
        end else begin
          rem_d   = ADD_WIDTH'(rem_x - left1_x);
          day_d   = DAY_FIRST;
          month_d = MONTH_JAN;
          year_d  = year_inc;
        end
      end else begin
        rem_d   = ADD_WIDTH'(rem_x - left1_x);
        day_d   = DAY_FIRST;
        month_d = month_q + 4'd1;
      end
    end else begin
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      month_q  <= MONTH_JAN;
      day_q    <= DAY_FIRST;
      year_q   <= YEAR_LO;
      leap_q   <= 1'b0;
      rem_q    <= '0;
      is_add_q <= 1'b0;
      ovf_q    <= 1'b0;
    end else begin
      month_q  <= month_d;
      day_q    <= day_d;
      year_q   <= year_d;
      leap_q   <= leap_d;
      rem_q    <= rem_d;
      is_add_q <= is_add_d;
      ovf_q    <= ovf_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      prev_month_q <= month_q;
      prev_day_q   <= day_q;
      prev_year_q  <= year_q;
    end
    if (cmd_i.out_load) begin
      res_q.prev_month    <= prev_month_q;
      res_q.prev_day      <= prev_day_q;
      res_q.prev_year     <= prev_year_q;
      res_q.cur_month     <= month_q;
      res_q.cur_day       <= day_q;
      res_q.cur_year      <= year_q;
      res_q.year_overflow <= ovf_q;
    end
  end

  assign res_o = res_q;

endmodule

FILE: hw/rtl/calendar_date_counter.sv
// Channel  Direction  Handshake                  Payload
// in       input      in_valid_i / in_stall_o    in_req_i  (req_t)
// out      output     out_valid_o / out_stall_i  out_res_o (res_t)
//
// One item is worked on at a time. A set runs the leap-year test and the day fix;
// an add runs the leap-year test, then steps (finish inside the month, move to the
// next month, skip a whole year, or stop at the year cap), with the leap-year test
// again after each change of year. Reset loads 1 Jan 1900. A stalled result keeps
// its register, and the next item may be accepted while it waits.
module calendar_date_counter
  import cdc_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  req_t in_req_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output res_t out_res_o
);

  cmd_t  cmd;
  stat_t stat;

  cdc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  cdc_dpath u_dpath (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (in_req_i),
    .cmd_i  (cmd),
    .stat_o (stat),
    .res_o  (out_res_o)
  );

endmodule

FILE: dv/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import cdc_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 3_000_000;
  localparam int unsigned DRAIN_CYCLES = 50;
  localparam int unsigned RANDOM_ITEMS = 1100;

  typedef struct {
    req_t req;
    int   reps;
    bit   typed;
    res_t want;
  } stim_row_t;

  logic clk;
  logic rst_n     = 1'b0;
  logic in_valid  = 1'b0;
  logic in_stall;
  req_t in_req    = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  res_t out_res;

  bit          quiet = 1'b0;
  int unsigned cycle_cnt = 0;
  int unsigned errors = 0;
  int unsigned n_sets = 0;
  int unsigned n_adds = 0;
  int unsigned n_checked = 0;
  int unsigned n_capped = 0;

  logic [3:0]            cal_month = MONTH_JAN;
  logic [4:0]            cal_day   = DAY_FIRST;
  logic [YEAR_WIDTH-1:0] cal_year  = YEAR_LO;

  res_t      expected_dates[$];
  stim_row_t stim_rows[$];
  res_t      want_res;

  calendar_date_counter dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_req_i    (in_req),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_res_o   (out_res)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic bit leap_year(input int unsigned y);
    return (y % 400 == 0) || ((y % 100 != 0) && (y % 4 == 0));
  endfunction

  function automatic int unsigned month_days(input int unsigned m, input int unsigned y);
    int unsigned lens[13] = '{0, 31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
    if (m == MONTH_FEB && leap_year(y)) begin
      return 29;
    end
    return lens[m];
  endfunction

  // Applies one request to the tracked date and returns the result it causes.
  function automatic res_t apply_request(input req_t r);
    res_t            res;
    int unsigned     m;
    int unsigned     d;
    int unsigned     y;
    int unsigned     left;
    int unsigned     ylen;
    int unsigned     days;
    bit              ovf;
    m   = 32'(cal_month);
    d   = 32'(cal_day);
    y   = 32'(cal_year);
    ovf = 1'b0;
    res.prev_month = cal_month;
    res.prev_day   = cal_day;
    res.prev_year  = cal_year;
    if (r.req_type == REQ_SET) begin
      m = 32'((r.set_month >= MONTH_JAN && r.set_month <= MONTH_DEC) ? r.set_month
                                                                      : MONTH_JAN);
      y = 32'((r.set_year >= YEAR_LO && r.set_year <= YEAR_HI) ? r.set_year : YEAR_LO);
      d = (r.set_day >= DAY_FIRST && r.set_day <= month_days(m, y)) ? 32'(r.set_day)
                                                                    : 32'(DAY_FIRST);
    end else begin
      days = 32'(r.add_days);
      while (days > 0) begin
        left = month_days(m, y) - d;
        ylen = leap_year(y) ? 366 : 365;
        if (m == MONTH_JAN && d == DAY_FIRST && y < YEAR_MAX && days >= ylen) begin
          days -= ylen;
          y++;
        end else if (days <= left) begin
          d += days;
          days = 0;
        end else if (m == MONTH_DEC) begin
          if (y >= YEAR_MAX) begin
            d    = 32'(DAY_LAST);
            ovf  = 1'b1;
            days = 0;
          end else begin
            days -= left + 1;
            d = 32'(DAY_FIRST);
            m = 32'(MONTH_JAN);
            y++;
          end
        end else begin
          days -= left + 1;
          d = 32'(DAY_FIRST);
          m++;
        end
      end
    end
    cal_month = 4'(m);
    cal_day   = 5'(d);
    cal_year  = YEAR_WIDTH'(y);
    res.cur_month     = cal_month;
    res.cur_day       = cal_day;
    res.cur_year      = cal_year;
    res.year_overflow = ovf;
    return res;
  endfunction

  function automatic req_t mk_set(input int unsigned m, input int unsigned d,
                                  input int unsigned y);
    req_t r;
    r.req_type  = REQ_SET;
    r.set_month = 4'(m);
    r.set_day   = 5'(d);
    r.set_year  = YEAR_WIDTH'(y);
    r.add_days  = ADD_WIDTH'($urandom);
    return r;
  endfunction

  function automatic req_t mk_add(input int unsigned n);
    req_t r;
    r.req_type  = REQ_ADD;
    r.set_month = 4'($urandom);
    r.set_day   = 5'($urandom);
    r.set_year  = YEAR_WIDTH'($urandom);
    r.add_days  = ADD_WIDTH'(n);
    return r;
  endfunction

  function automatic res_t mk_res(input int unsigned pm, input int unsigned pd,
                                  input int unsigned py, input int unsigned cm,
                                  input int unsigned cd, input int unsigned cy,
                                  input bit ovf);
    res_t res;
    res.prev_month    = 4'(pm);
    res.prev_day      = 5'(pd);
    res.prev_year     = YEAR_WIDTH'(py);
    res.cur_month     = 4'(cm);
    res.cur_day       = 5'(cd);
    res.cur_year      = YEAR_WIDTH'(cy);
    res.year_overflow = ovf;
    return res;
  endfunction

  task automatic add_row(input req_t r, input int reps, input bit typed, input res_t want);
    stim_row_t row;
    row.req   = r;
    row.reps  = reps;
    row.typed = typed;
    row.want  = want;
    stim_rows.push_back(row);
  endtask

  task automatic drive_request(input req_t r, input bit typed, input res_t want);
    res_t pred;
    if (!quiet && $urandom_range(99) < 33) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < 33);
    end
    in_valid <= 1'b1;
    in_req   <= r;
    do @(posedge clk); while (in_stall);
    pred = apply_request(r);
    expected_dates.push_back(typed ? want : pred);
    if (r.req_type == REQ_SET) begin
      n_sets++;
    end else begin
      n_adds++;
    end
  endtask

  task automatic compare_field(input string name, input int unsigned want,
                               input int unsigned got);
    if (want != got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    out_stall <= quiet ? 1'b0 : ($urandom_range(99) < 33);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_dates.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, got %p", $time, out_res);
      end else begin
        want_res = expected_dates.pop_front();
        n_checked++;
        if (out_res.year_overflow) begin
          n_capped++;
        end
        compare_field("prev_month", 32'(want_res.prev_month), 32'(out_res.prev_month));
        compare_field("prev_day", 32'(want_res.prev_day), 32'(out_res.prev_day));
        compare_field("prev_year", 32'(want_res.prev_year), 32'(out_res.prev_year));
        compare_field("cur_month", 32'(want_res.cur_month), 32'(out_res.cur_month));
        compare_field("cur_day", 32'(want_res.cur_day), 32'(out_res.cur_day));
        compare_field("cur_year", 32'(want_res.cur_year), 32'(out_res.cur_year));
        compare_field("year_overflow", 32'(want_res.year_overflow),
                      32'(out_res.year_overflow));
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, expected_dates.size());
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    int   sent;
    int   pick;
    int   burst;
    req_t r;
    sent = 0;

    add_row(mk_set(0, 0, 0), 1, 1, mk_res(1, 1, 1900, 1, 1, 1900, 0));
    add_row(mk_set(15, 31, 4095), 1, 1, mk_res(1, 1, 1900, 1, 31, 1900, 0));
    add_row(mk_set(2, 29, 2000), 1, 1, mk_res(1, 31, 1900, 2, 29, 2000, 0));
    add_row(mk_set(2, 29, 1900), 1, 1, mk_res(2, 29, 2000, 2, 1, 1900, 0));
    add_row(mk_set(2, 29, 2100), 1, 1, mk_res(2, 1, 1900, 2, 1, 2100, 0));
    add_row(mk_set(4, 31, 2023), 1, 1, mk_res(2, 1, 2100, 4, 1, 2023, 0));
    add_row(mk_set(12, 31, 2100), 1, 1, mk_res(4, 1, 2023, 12, 31, 2100, 0));
    add_row(mk_add(0), 1, 1, mk_res(12, 31, 2100, 12, 31, 2100, 0));
    add_row(mk_add(1), 1, 1, mk_res(12, 31, 2100, 1, 1, 2101, 0));
    add_row(mk_set(12, 31, 1899), 1, 1, mk_res(1, 1, 2101, 12, 31, 1900, 0));
    add_row(mk_set(13, 0, 2001), 1, 1, mk_res(12, 31, 1900, 1, 1, 2001, 0));
    add_row(mk_add(365), 1, 1, mk_res(1, 1, 2001, 1, 1, 2002, 0));
    add_row(mk_set(2, 28, 2024), 1, 1, mk_res(1, 1, 2002, 2, 28, 2024, 0));
    add_row(mk_add(1), 1, 1, mk_res(2, 28, 2024, 2, 29, 2024, 0));
    add_row(mk_add(1), 1, 1, mk_res(2, 29, 2024, 3, 1, 2024, 0));
    add_row(mk_add(65535), 1, 0, '0);
    add_row(mk_add(45), 1, 0, '0);
    add_row(mk_set(12, 31, 2100), 1, 0, '0);
    add_row(mk_add(65535), 12, 0, '0);
    add_row(mk_add(1), 1, 1, mk_res(12, 31, 4095, 12, 31, 4095, 1));
    add_row(mk_add(0), 1, 1, mk_res(12, 31, 4095, 12, 31, 4095, 0));
    add_row(mk_add(65535), 1, 1, mk_res(12, 31, 4095, 12, 31, 4095, 1));
    add_row(mk_set(1, 1, 1900), 1, 1, mk_res(12, 31, 4095, 1, 1, 1900, 0));

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (stim_rows[i]) begin
      repeat (stim_rows[i].reps) begin
        drive_request(stim_rows[i].req, stim_rows[i].typed, stim_rows[i].want);
      end
    end

    while (sent < RANDOM_ITEMS) begin
      quiet = (sent >= 400 && sent < 600);
      pick  = $urandom_range(99);
      if (pick < 3) begin
        // Long run of large adds from late in the valid range up to the year cap.
        drive_request(mk_set($urandom_range(1, 12), $urandom_range(1, 31),
                             $urandom_range(2090, 2100)), 0, '0);
        burst = $urandom_range(13, 15);
        repeat (burst) begin
          drive_request(mk_add($urandom_range(60000, 65535)), 0, '0);
        end
        sent += burst + 1;
      end else begin
        if (pick < 28) begin
          r = mk_set($urandom_range(0, 15), $urandom_range(0, 31),
                     ($urandom_range(1) == 0) ? $urandom_range(1900, 2100)
                                              : $urandom_range(0, 4095));
        end else if (pick < 70) begin
          r = mk_add($urandom_range(0, 40));
        end else if (pick < 88) begin
          r = mk_add($urandom_range(41, 1500));
        end else begin
          r = mk_add($urandom_range(0, 65535));
        end
        drive_request(r, 0, '0);
        sent++;
      end
    end
    quiet = 1'b0;
    in_valid <= 1'b0;

    while (expected_dates.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Drove %0d set and %0d add requests, directed table and random mix.",
             n_sets, n_adds);
    $display("Compared %0d results, %0d of them stopped at the year cap; %0d errors.",
             n_checked, n_capped, errors);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
